@@ src/olist_pkg.sv @@
// Shared constants, types and codes for the ordered list engine.
`default_nettype none
package olist_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 4;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;
	localparam int CNT_OUT_W = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_READ       = 3'd0,
		OP_FIND       = 3'd1,
		OP_INSERT     = 3'd2,
		OP_DELETE     = 3'd3,
		OP_PUSH_FRONT = 3'd4,
		OP_PUSH_BACK  = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic exec;
	} cmd_t;

endpackage
`default_nettype wire

@@ src/olist_ctrl.sv @@
// Controller: request handshake and result register occupancy.
`default_nettype none
module olist_ctrl
	import olist_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	typedef enum logic {
		S_EMPTY,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;
	assign cmd.exec  = accept;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_EMPTY: begin
					if (accept) begin
						state_q     <= S_HOLD;
						out_valid_q <= 1'b1;
					end
				end
				S_HOLD: begin
					if (accept) begin
						state_q     <= S_HOLD;
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						state_q     <= S_EMPTY;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_EMPTY;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request gave no result");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request taken while result stalled");

	a_valid_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q == (state_q == S_HOLD))
		else $error("result valid disagrees with state");

endmodule
`default_nettype wire

@@ src/olist_dp.sv @@
// Datapath: shifting entry cells, parallel search and result registers.
`default_nettype none
module olist_dp
	import olist_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic signed [VAL_W-1:0] value,
	output logic signed [VAL_W-1:0] read_value,
	output logic [POS_W-1:0]       found_position,
	output logic [STAT_W-1:0]      status,
	output logic [CNT_OUT_W-1:0]   count,
	output logic                   empty_res
);

	logic [VAL_W-1:0]  entries_q [CAPACITY];
	logic [VAL_W-1:0]  entries_nxt [CAPACITY];
	logic [CNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic [CNT_W-1:0]  at;
	logic              full;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              do_ins;
	logic              do_del;
	logic [VAL_W-1:0]  rd;
	logic [POS_W-1:0]  fp;
	status_t           st;

	logic signed [VAL_W-1:0] read_value_q;
	logic [POS_W-1:0]        found_q;
	status_t                 status_q;
	logic [CNT_OUT_W-1:0]    count_q;
	logic                    empty_q;

	always_comb begin
		pos_c   = CMP_W'(position);
		cnt_c   = CMP_W'(entry_count_q);
		full    = entry_count_q == CNT_W'(CAPACITY);
		hit     = 1'b0;
		hit_idx = '0;
		// scan from the top so the lowest match wins
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < entry_count_q) && (entries_q[i] == value)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
		do_ins = 1'b0;
		do_del = 1'b0;
		at     = '0;
		rd     = '0;
		fp     = '0;
		st     = ST_OK;
		case (op_t'(op))
			OP_READ: begin
				if (pos_c < cnt_c) rd = entries_q[IDX_W'(position)];
				else st = ST_RANGE;
			end
			OP_FIND: begin
				if (hit) fp = POS_W'(hit_idx);
				else st = ST_NOTFOUND;
			end
			OP_INSERT: begin
				if (full) st = ST_FULL;
				else if (pos_c > cnt_c) st = ST_RANGE;
				else begin
					do_ins = 1'b1;
					at     = CNT_W'(pos_c);
				end
			end
			OP_DELETE: begin
				if (pos_c >= cnt_c) st = ST_RANGE;
				else begin
					do_del = 1'b1;
					at     = CNT_W'(pos_c);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			OP_PUSH_BACK: begin
				if (full) st = ST_FULL;
				else begin
					do_ins = 1'b1;
					at     = entry_count_q;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase

		count_nxt = entry_count_q;
		if (do_ins) count_nxt = entry_count_q + 1'b1;
		else if (do_del) count_nxt = entry_count_q - 1'b1;

		for (int i = 0; i < CAPACITY; i++) begin
			entries_nxt[i] = entries_q[i];
			if (do_ins) begin
				if (CNT_W'(i) == at) entries_nxt[i] = value;
				else if (CNT_W'(i) > at) entries_nxt[i] = entries_q[(i > 0) ? i - 1 : 0];
			end else if (do_del) begin
				if ((CNT_W'(i) >= at) && (i < CAPACITY - 1))
					entries_nxt[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cmd.exec) begin
			entry_count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++) entries_q[i] <= entries_nxt[i];
			read_value_q <= rd;
			found_q      <= fp;
			status_q     <= st;
			count_q      <= CNT_OUT_W'(count_nxt);
			empty_q      <= count_nxt == '0;
		end
	end

	assign read_value     = read_value_q;
	assign found_position = found_q;
	assign status         = status_q;
	assign count          = count_q;
	assign empty_res      = empty_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !full && (op_t'(op) == OP_PUSH_BACK)) |=>
		(entry_count_q == CNT_W'($past(entry_count_q) + 1'b1)))
		else $error("push did not grow the list");

	a_empty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (empty_q == (entry_count_q == '0)))
		else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

@@ src/ordered_list_engine_top.sv @@
// Ordered list engine: top level joining controller and datapath.
//
// A fixed-capacity ordered list of signed 32-bit entries. Each request on
// the input channel (in_valid/in_ready with op, position, value) does one
// op: read, find, insert at, delete at, push front or push back. Each
// request gives exactly one result on the output channel (out_valid/
// out_ready with read_value, found_position, status, count, empty_res).
// The result is registered: valid in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; every op,
// shifts and search included, is a parallel compare and register cell update.
// The result register frees itself in the cycle it is taken, so a new
// request enters while the previous result is being read.
// When the receiver stalls, the result holds and in_ready drops until it
// is taken. Reset empties the list (count zero) and clears the result
// valid; entry contents are not cleared and are never read before written.
`default_nettype none
module ordered_list_engine_top
	import olist_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [VAL_W-1:0]      read_value,
	output logic [POS_W-1:0]             found_position,
	output logic [STAT_W-1:0]            status,
	output logic [CNT_OUT_W-1:0]         count,
	output logic                         empty_res
);

	cmd_t cmd;

	olist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	olist_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (op),
		.position       (position),
		.value          (value),
		.read_value     (read_value),
		.found_position (found_position),
		.status         (status),
		.count          (count),
		.empty_res      (empty_res)
	);

endmodule
`default_nettype wire
